// ===== sv/htok_pkg.sv =====
// htok_pkg: shared types and constants for the HTTP header tokenizer.
// Item structs for both channels, queue entry, result kind codes.
// No dependencies.
package htok_pkg;

  localparam int MAX_HEADERS = 128;
  localparam int FIELD_BYTES = 1024;

  localparam int HC_W = $clog2(MAX_HEADERS + 1);
  localparam int FP_W = $clog2(FIELD_BYTES + 2);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int APB_AW = 3;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'd58;

  localparam logic [3:0] MAX_BL_RST = 4'd5;

  localparam logic [2:0] KIND_KEY   = 3'd0;
  localparam logic [2:0] KIND_VALUE = 3'd1;
  localparam logic [2:0] KIND_HDONE = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_BLERR = 3'd4;
  localparam logic [2:0] KIND_OVF   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_message;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [6:0] header_number;
    logic [9:0] char_position;
    logic       last;
  } out_item_t;

  // up to two results per input item
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } entry_t;

endpackage

// ===== sv/htok_front.sv =====
// htok_front: accepts bytes, runs the header parse state and forms
// the results of each byte as one queue entry. Depends on htok_pkg.
module htok_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  htok_pkg::in_item_t in_item_i,
  input  logic [3:0]        max_bl_i,
  output logic              push_o,
  output htok_pkg::entry_t  push_data_o,
  input  logic              full_i
);
  import htok_pkg::*;

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_REQ   = 3'd1;
  localparam logic [2:0] PH_KEY   = 3'd2;
  localparam logic [2:0] PH_VALUE = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_ERROR = 3'd5;

  typedef struct packed {
    logic [2:0]      phase;
    logic            crp;
    logic            ls;
    logic            sk;
    logic [3:0]      blc;
    logic [HC_W-1:0] hc;
    logic [FP_W-1:0] fp;
  } parse_t;

  typedef struct packed {
    parse_t    s;
    logic      emit;
    out_item_t res;
  } step_t;

  localparam parse_t PARSE_RST = '{phase: PH_LEAD, crp: 1'b0, ls: 1'b1, sk: 1'b0,
                                   blc: '0, hc: '0, fp: '0};

  function automatic out_item_t mk(logic [2:0] kind, logic [7:0] b,
                                   logic [FP_W-1:0] fp, logic [HC_W-1:0] hc);
    out_item_t o;
    o.kind          = kind;
    o.out_byte      = b;
    o.header_number = (32'(hc) > 32'd127) ? 7'd127 : 7'(hc);
    o.char_position = 10'(fp);
    o.last          = 1'b0;
    return o;
  endfunction

  function automatic step_t nop(parse_t s);
    step_t r;
    r.s    = s;
    r.emit = 1'b0;
    r.res  = '0;
    return r;
  endfunction

  function automatic step_t put_data(parse_t s, logic [2:0] kind, logic [7:0] b);
    step_t r;
    r = nop(s);
    if (32'(s.hc) < MAX_HEADERS) begin
      if (32'(s.fp) < FIELD_BYTES) begin
        r.emit = 1'b1;
        r.res  = mk(kind, b, s.fp, s.hc);
        r.s.fp = s.fp + 1'b1;
      end else if (32'(s.fp) == FIELD_BYTES) begin
        r.emit = 1'b1;
        r.res  = mk(KIND_OVF, 8'd0, '0, s.hc);
        r.s.fp = s.fp + 1'b1;
      end
    end
    return r;
  endfunction

  function automatic step_t finish_header(parse_t s);
    step_t r;
    r = nop(s);
    r.emit = 1'b1;
    if (32'(s.hc) < MAX_HEADERS) begin
      r.res  = mk(KIND_HDONE, 8'd0, '0, s.hc);
      r.s.hc = s.hc + 1'b1;
    end else begin
      r.res  = mk(KIND_OVF, 8'd0, '0, s.hc);
    end
    r.s.phase = PH_KEY;
    r.s.ls    = 1'b1;
    r.s.sk    = 1'b0;
    r.s.fp    = '0;
    return r;
  endfunction

  function automatic step_t line_end(parse_t s, logic [3:0] m);
    step_t r;
    r = nop(s);
    case (s.phase)
      PH_LEAD: begin
        if (s.blc >= m) begin
          r.emit    = 1'b1;
          r.res     = mk(KIND_BLERR, 8'd0, '0, '0);
          r.s.phase = PH_ERROR;
        end else begin
          r.s.blc = s.blc + 1'b1;
        end
      end
      PH_REQ: begin
        r.s.phase = PH_KEY;
        r.s.ls    = 1'b1;
        r.s.fp    = '0;
      end
      PH_KEY: begin
        if (s.ls) begin
          r.emit    = 1'b1;
          r.res     = mk(KIND_END, 8'd0, '0, s.hc);
          r.s.phase = PH_DONE;
        end else begin
          r = finish_header(s);
        end
      end
      PH_VALUE: r = finish_header(s);
      default: r = nop(s);
    endcase
    return r;
  endfunction

  function automatic step_t cr_as_data(parse_t s);
    step_t r;
    parse_t t;
    r = nop(s);
    t = s;
    if (s.phase == PH_LEAD) begin
      r.s.phase = PH_REQ;
    end else if (s.phase == PH_KEY) begin
      t.ls = 1'b0;
      r = put_data(t, KIND_KEY, CH_CR);
    end else if (s.phase == PH_VALUE) begin
      r = put_data(s, KIND_VALUE, CH_CR);
    end
    return r;
  endfunction

  function automatic step_t take_byte(parse_t s, logic [7:0] b, logic [3:0] m);
    step_t r;
    parse_t t;
    r = nop(s);
    t = s;
    if (s.phase inside {PH_LEAD, PH_REQ, PH_KEY, PH_VALUE}) begin
      if (s.phase == PH_VALUE && s.sk) begin
        if (b == CH_LF) r = line_end(s, m);
        else r.s.sk = 1'b0;
      end else if (b == CH_CR) begin
        r.s.crp = 1'b1;
      end else if (b == CH_LF) begin
        r = line_end(s, m);
      end else if (s.phase == PH_LEAD) begin
        r.s.phase = PH_REQ;
      end else if (s.phase == PH_KEY) begin
        t.ls = 1'b0;
        if (b == CH_COLON) begin
          r.s       = t;
          r.s.phase = PH_VALUE;
          r.s.sk    = 1'b1;
          r.s.fp    = '0;
        end else begin
          r = put_data(t, KIND_KEY, b);
        end
      end else if (s.phase == PH_VALUE) begin
        r = put_data(s, KIND_VALUE, b);
      end
    end
    return r;
  endfunction

  parse_t st_q, st_d;
  step_t  ev_a, ev_b;
  parse_t s0;
  logic   accept;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  always_comb begin
    s0   = in_item_i.start_of_message ? PARSE_RST : st_q;
    ev_a = nop(s0);
    ev_b = nop(s0);
    if (s0.crp) begin
      ev_a = nop(s0);
      ev_a.s.crp = 1'b0;
      if (in_item_i.data_byte == CH_LF) begin
        ev_a = line_end(ev_a.s, max_bl_i);
        ev_b = nop(ev_a.s);
      end else begin
        ev_a = cr_as_data(ev_a.s);
        ev_b = take_byte(ev_a.s, in_item_i.data_byte, max_bl_i);
      end
    end else begin
      ev_b = take_byte(s0, in_item_i.data_byte, max_bl_i);
    end
    st_d = ev_b.s;

    push_data_o.two     = ev_a.emit && ev_b.emit;
    push_data_o.r0      = ev_a.emit ? ev_a.res : ev_b.res;
    push_data_o.r0.last = !(ev_a.emit && ev_b.emit);
    push_data_o.r1      = ev_b.res;
    push_data_o.r1.last = 1'b1;
  end

  assign push_o = accept && (ev_a.emit || ev_b.emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PARSE_RST;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

endmodule

// ===== sv/htok_fifo.sv =====
// htok_fifo: short queue of result entries between front and back.
// Depends on htok_pkg.
module htok_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  htok_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output htok_pkg::entry_t head_o,
  output logic             empty_o
);
  import htok_pkg::*;

  entry_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_AW:0]     cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (32'(cnt_q) == FIFO_DEPTH);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== sv/htok_back.sv =====
// htok_back: drains queue entries one result at a time into the output
// register. Depends on htok_pkg.
module htok_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  htok_pkg::entry_t   head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output htok_pkg::out_item_t out_item_o
);
  import htok_pkg::*;

  logic      valid_q;
  out_item_t item_q;
  logic      sub_q;
  logic      load;

  assign load        = (!valid_q || !out_stall_i) && !empty_i;
  assign pop_o       = load && (sub_q || !head_i.two);
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= sub_q ? head_i.r1 : head_i.r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= !empty_i;
      if (load) sub_q <= !(sub_q || !head_i.two);
    end
  end

endmodule

// ===== sv/http_header_tokenizer.sv =====
// http_header_tokenizer: top level, config register and APB port.
// Depends on htok_pkg, htok_front, htok_fifo, htok_back.
//
// Input channel: one request byte per item, start_of_message restarts the
// parse. Output channel: tagged key/value bytes and markers (header done,
// headers ended, blank-line error, overflow); last marks the final result
// of an input byte. Zero to two results per byte.
// A byte's results go through the queue and then the output register.
// Throughput: one byte per cycle if each gives at most one result and the
// output does not stall; two results take the single output register in turn.
// A four-entry queue lets input run ahead of a stalled output; the input
// stalls only when that queue is full.
// APB: register 0 (address 0) is max_leading_blank_lines, 4 bits, reset 5.
// Write it only while the block is idle.
// Reset clears the parse state, the queue and the output valid.
module http_header_tokenizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  htok_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output htok_pkg::out_item_t       out_item_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [htok_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import htok_pkg::*;

  logic [3:0] max_bl_q;
  logic       push, full, pop, empty;
  entry_t     push_data, head;

  assign pready = 1'b1;
  assign prdata = paddr[APB_AW-1] ? 32'd0 : {28'd0, max_bl_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bl_q <= MAX_BL_RST;
    end else if (psel && penable && pwrite && !paddr[APB_AW-1]) begin
      max_bl_q <= pwdata[3:0];
    end
  end

  htok_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .max_bl_i    (max_bl_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  htok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  htok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sv/htok_checker.sv =====
// htok_checker: port-level assertions for http_header_tokenizer,
// attached by bind. Depends on htok_pkg.
module htok_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input htok_pkg::out_item_t         out_item_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [htok_pkg::APB_AW-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata
);
  import htok_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_HDONE || out_item_o.kind == KIND_END ||
                    out_item_o.kind == KIND_BLERR || out_item_o.kind == KIND_OVF)
    |-> out_item_o.out_byte == 8'd0 && out_item_o.char_position == 10'd0)
    else $error("marker carries byte or position");

  a_blerr_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_BLERR
    |-> out_item_o.header_number == 7'd0 && out_item_o.last)
    else $error("blank-line error with header number or not last");

  a_cfg_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && !paddr[APB_AW-1]
    |=> paddr[APB_AW-1] || prdata[3:0] == $past(pwdata[3:0]))
    else $error("config register readback mismatch");

endmodule

bind http_header_tokenizer htok_checker u_htok_checker (.*);
